>>> rtl/iiwd_pkg.sv
// package for the imu idle window detector
// types and constants shared by the rtl files; no dependencies
package iiwd_pkg;
	localparam int WindowLenDef = 64;
	localparam int StrideDef = 10;
	localparam int IndexBitsDef = 24;
	localparam int AxisBits = 12;
	localparam int Axes = 6;
	localparam int SampleBits = AxisBits * Axes;
	localparam int SumBits = 18;
	localparam int SpreadBits = 13;
	localparam int TotalBits = 14;
	localparam int StartBits = 24;
	localparam logic [SpreadBits-1:0] SpreadReset = 13'd50;
	localparam logic [SumBits-1:0] SumMax = '1;

	typedef struct packed {
		logic record_start;
		logic [AxisBits-1:0] accel_x;
		logic [AxisBits-1:0] accel_y;
		logic [AxisBits-1:0] accel_z;
		logic [AxisBits-1:0] gyro_x;
		logic [AxisBits-1:0] gyro_y;
		logic [AxisBits-1:0] gyro_z;
	} sample_t;

	typedef struct packed {
		logic [StartBits-1:0] window_start;
		logic [SumBits-1:0] accel_x_sum;
		logic [SumBits-1:0] accel_y_sum;
		logic [SumBits-1:0] accel_z_sum;
		logic [SumBits-1:0] gyro_x_sum;
		logic [SumBits-1:0] gyro_y_sum;
		logic [SumBits-1:0] gyro_z_sum;
		logic [TotalBits-1:0] accel_spread_total;
	} report_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_JUDGE,
		ST_OUT
	} scan_state_t;
endpackage

>>> rtl/iiwd_if.sv
// channel interfaces for the imu idle window detector
// depends on iiwd_pkg
interface iiwd_sample_if;
	import iiwd_pkg::*;
	logic valid;
	logic ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface iiwd_report_if;
	import iiwd_pkg::*;
	logic valid;
	logic ready;
	report_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/iiwd_front.sv
// front part: takes samples, writes the ring, tracks the index, queues window jobs
// depends on iiwd_pkg
module iiwd_front #(
	parameter int WINDOW_LEN = iiwd_pkg::WindowLenDef,
	parameter int STRIDE = iiwd_pkg::StrideDef,
	parameter int INDEX_BITS = iiwd_pkg::IndexBitsDef,
	localparam int PtrBits = $clog2(WINDOW_LEN)
) (
	input logic clk,
	input logic arst_n,
	iiwd_sample_if.sink smp,
	output logic wr_en,
	output logic [PtrBits-1:0] wr_addr,
	output logic [iiwd_pkg::SampleBits-1:0] wr_data,
	output logic job_valid,
	input logic job_ready,
	output logic [iiwd_pkg::StartBits-1:0] job_start
);
	import iiwd_pkg::*;
	localparam int StrBits = (STRIDE > 1) ? $clog2(STRIDE) : 1;

	logic [INDEX_BITS-1:0] index_q;
	logic [PtrBits-1:0] wptr_q;
	logic [StrBits-1:0] phase_q;
	logic [INDEX_BITS-1:0] idx;
	logic [INDEX_BITS-1:0] first_idx;
	logic [StrBits-1:0] phase;
	logic completes;
	// one-deep job slot
	logic job_valid_q;
	logic [StartBits-1:0] job_start_q;

	// ring is written ahead of the scan; only accept when the job slot is free
	assign smp.ready = !job_valid_q;
	assign wr_en = smp.valid && smp.ready;
	assign wr_addr = wptr_q;
	assign wr_data = {smp.data.accel_x, smp.data.accel_y, smp.data.accel_z,
		smp.data.gyro_x, smp.data.gyro_y, smp.data.gyro_z};
	assign idx = smp.data.record_start ? '0 : index_q;
	assign phase = (smp.data.record_start || index_q == '0) ? '0 : phase_q;
	assign first_idx = idx - INDEX_BITS'(WINDOW_LEN - 1);
	assign completes = (idx >= INDEX_BITS'(WINDOW_LEN - 1)) && (phase == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			wptr_q <= '0;
			phase_q <= '0;
			job_valid_q <= 1'b0;
		end else begin
			if (job_valid_q && job_ready)
				job_valid_q <= 1'b0;
			if (wr_en) begin
				index_q <= idx + 1'b1;
				wptr_q <= (wptr_q == PtrBits'(WINDOW_LEN - 1)) ? '0 : wptr_q + 1'b1;
				// phase counts samples past window_len-1 modulo stride
				if (idx < INDEX_BITS'(WINDOW_LEN - 1))
					phase_q <= '0;
				else
					phase_q <= (phase == StrBits'(STRIDE - 1)) ? '0 : phase + 1'b1;
				if (completes)
					job_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && completes)
			job_start_q <= StartBits'(first_idx);
	end

	assign job_valid = job_valid_q;
	assign job_start = job_start_q;
endmodule

>>> rtl/iiwd_back.sv
// back part: ring memory, scan over the window, idle judge and output register
// depends on iiwd_pkg
module iiwd_back #(
	parameter int WINDOW_LEN = iiwd_pkg::WindowLenDef,
	localparam int PtrBits = $clog2(WINDOW_LEN)
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [PtrBits-1:0] wr_addr,
	input logic [iiwd_pkg::SampleBits-1:0] wr_data,
	input logic job_valid,
	output logic job_ready,
	input logic [iiwd_pkg::StartBits-1:0] job_start,
	input logic [iiwd_pkg::SpreadBits-1:0] max_spread,
	iiwd_report_if.source rpt,
	output logic busy
);
	import iiwd_pkg::*;
	localparam int CntBits = $clog2(WINDOW_LEN + 1);
	localparam int AccBits = $clog2(WINDOW_LEN) + AxisBits + 1;

	logic [SampleBits-1:0] ring [WINDOW_LEN];
	logic [SampleBits-1:0] rd_data_q;
	logic [PtrBits-1:0] rd_addr;
	logic [CntBits-1:0] cnt_q;
	logic rd_valid_q;
	scan_state_t state_q, state_d;
	logic [AxisBits-1:0] lo_q [Axes];
	logic [AxisBits-1:0] hi_q [Axes];
	logic [AccBits-1:0] acc_q [Axes];
	logic first_q;
	logic [StartBits-1:0] start_q;
	logic idle;
	logic [TotalBits-1:0] total;
	report_t rpt_q;
	logic rpt_valid_q;
	logic rpt_load;

	function automatic logic [SumBits-1:0] sat(input logic [AccBits-1:0] v);
		logic [AccBits+SumBits-1:0] w;
		w = (AccBits+SumBits)'(v);
		return (w > (AccBits+SumBits)'(SumMax)) ? SumMax : w[SumBits-1:0];
	endfunction

	// the output register takes a new report once the previous one is gone
	assign rpt_load = (state_q == ST_OUT) && (!rpt_valid_q || rpt.ready);

	always_ff @(posedge clk) begin
		if (wr_en)
			ring[wr_addr] <= wr_data;
		rd_data_q <= ring[rd_addr];
	end

	assign rd_addr = cnt_q[PtrBits-1:0];

	always_comb begin
		state_d = state_q;
		job_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid)
					state_d = ST_SCAN;
			end
			ST_SCAN:
				if (!rd_valid_q && cnt_q == CntBits'(WINDOW_LEN))
					state_d = ST_JUDGE;
			ST_JUDGE:
				state_d = idle ? ST_OUT : ST_IDLE;
			ST_OUT:
				if (rpt_load)
					state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rd_valid_q <= 1'b0;
			rpt_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rpt_load)
				rpt_valid_q <= 1'b1;
			else if (rpt.ready)
				rpt_valid_q <= 1'b0;
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
				rd_valid_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				rd_valid_q <= cnt_q < CntBits'(WINDOW_LEN);
				if (cnt_q < CntBits'(WINDOW_LEN))
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// accumulate min, max and sum, one ring entry a cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			start_q <= job_start;
			first_q <= 1'b1;
		end
		if (rd_valid_q) begin
			first_q <= 1'b0;
			for (int a = 0; a < Axes; a++) begin
				if (first_q) begin
					lo_q[a] <= rd_data_q[(Axes-1-a)*AxisBits +: AxisBits];
					hi_q[a] <= rd_data_q[(Axes-1-a)*AxisBits +: AxisBits];
					acc_q[a] <= AccBits'(rd_data_q[(Axes-1-a)*AxisBits +: AxisBits]);
				end else begin
					if (rd_data_q[(Axes-1-a)*AxisBits +: AxisBits] < lo_q[a])
						lo_q[a] <= rd_data_q[(Axes-1-a)*AxisBits +: AxisBits];
					if (rd_data_q[(Axes-1-a)*AxisBits +: AxisBits] > hi_q[a])
						hi_q[a] <= rd_data_q[(Axes-1-a)*AxisBits +: AxisBits];
					acc_q[a] <= acc_q[a] + AccBits'(rd_data_q[(Axes-1-a)*AxisBits +: AxisBits]);
				end
			end
		end
		if (rpt_load) begin
			rpt_q.window_start <= start_q;
			rpt_q.accel_x_sum <= sat(acc_q[0]);
			rpt_q.accel_y_sum <= sat(acc_q[1]);
			rpt_q.accel_z_sum <= sat(acc_q[2]);
			rpt_q.gyro_x_sum <= sat(acc_q[3]);
			rpt_q.gyro_y_sum <= sat(acc_q[4]);
			rpt_q.gyro_z_sum <= sat(acc_q[5]);
			rpt_q.accel_spread_total <= total;
		end
	end

	always_comb begin
		idle = 1'b1;
		total = '0;
		for (int a = 0; a < Axes; a++)
			if (SpreadBits'(hi_q[a] - lo_q[a]) >= max_spread)
				idle = 1'b0;
		for (int a = 0; a < 3; a++)
			total = total + TotalBits'(hi_q[a] - lo_q[a]);
	end

	assign rpt.valid = rpt_valid_q;
	assign rpt.data = rpt_q;
	assign busy = (state_q != ST_IDLE) || job_valid;
endmodule

>>> rtl/imu_idle_window_detector.sv
// imu idle window detector, top level
// depends on iiwd_pkg, iiwd_if, iiwd_front and iiwd_back
// A sample is taken per transaction and written at once into a ring of
// WINDOW_LEN entries. When a sample closes a window (every STRIDE samples
// once WINDOW_LEN samples of the record are in), a job passes to the back
// part, which walks the ring one entry a cycle through the single read port,
// so a window holds off new samples while the ring is walked and judged, also
// while an idle window's report is loaded, and longer while an earlier report
// still sits unaccepted in the output register. Idle windows leave through a
// registered report transaction.
module imu_idle_window_detector #(
	parameter int WINDOW_LEN = iiwd_pkg::WindowLenDef,
	parameter int STRIDE = iiwd_pkg::StrideDef,
	parameter int INDEX_BITS = iiwd_pkg::IndexBitsDef
) (
	input logic clk,
	input logic arst_n,
	iiwd_sample_if.sink smp,
	iiwd_report_if.source rpt,
	input logic cfg_we,
	input logic [iiwd_pkg::SpreadBits-1:0] cfg_wdata
);
	import iiwd_pkg::*;
	localparam int PtrBits = $clog2(WINDOW_LEN);

	logic [SpreadBits-1:0] max_spread_q;
	logic wr_en;
	logic [PtrBits-1:0] wr_addr;
	logic [SampleBits-1:0] wr_data;
	logic job_valid, job_ready, busy;
	logic [StartBits-1:0] job_start;
	iiwd_sample_if smp_int();

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_spread_q <= SpreadReset;
		else if (cfg_we)
			max_spread_q <= cfg_wdata;
	end

	// hold off the next sample while the back part is busy, so the ring is stable
	assign smp_int.valid = smp.valid && !busy;
	assign smp_int.data = smp.data;
	assign smp.ready = smp_int.ready && !busy;

	iiwd_front #(.WINDOW_LEN(WINDOW_LEN), .STRIDE(STRIDE), .INDEX_BITS(INDEX_BITS)) u_front (
		.clk, .arst_n, .smp(smp_int), .wr_en, .wr_addr, .wr_data,
		.job_valid, .job_ready, .job_start
	);

	iiwd_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
		.clk, .arst_n, .wr_en, .wr_addr, .wr_data, .job_valid, .job_ready,
		.job_start, .max_spread(max_spread_q), .rpt, .busy
	);

`ifndef SYNTHESIS
	// no sample enters while a window is being walked
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en) else $error("sample written during scan");
	// a pending report keeps its payload until taken
	a_rpt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && !rpt.ready |=> rpt.valid && $stable(rpt.data))
		else $error("report dropped");
`endif
endmodule
